@@ rtl/ipdt_pkg.sv @@
// Shared constants and beat types for the index pair dedup table.
`timescale 1ns / 1ps

package ipdt_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 32;
  localparam int IDX_OUT_W = 10;
  localparam int CNT_OUT_W = 11;

  typedef struct packed {
    logic [15:0] vertex_index;
    logic [15:0] texcoord_index;
    logic        start_mesh;
  } pair_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] canonical_index;
    logic                 was_added;
    logic                 table_full;
    logic [CNT_OUT_W-1:0] entry_count;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic resolve;
    logic publish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic exhausted;
  } status_t;

endpackage

@@ rtl/ipdt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ipdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ipdt_dp.sv @@
// Datapath: pair key, entry count, scan pointer, table RAM and result registers.
`timescale 1ns / 1ps

module ipdt_dp (
  input  logic             clk,
  input  logic             rst,
  input  ipdt_pkg::cmd_t   cmd,
  output ipdt_pkg::status_t status,
  input  ipdt_pkg::pair_t  pair,
  output ipdt_pkg::result_t result
);

  logic [ipdt_pkg::KEY_W-1:0]  key;
  logic [ipdt_pkg::CNT_W-1:0]  count;
  logic [ipdt_pkg::CNT_W-1:0]  count_next;
  logic [ipdt_pkg::CNT_W-1:0]  idx;
  logic                        pend_valid;
  logic [ipdt_pkg::ADDR_W-1:0] pend_idx;
  logic [ipdt_pkg::KEY_W-1:0]  rdata;
  logic                        issue;
  logic                        room;
  logic                        wr_en;
  ipdt_pkg::result_t           res;
  ipdt_pkg::result_t           res_next;
  logic [ipdt_pkg::ADDR_W-1:0] pos;

  // read data belongs to pend_idx, issued the cycle before
  assign status.hit       = pend_valid && (rdata == key);
  assign status.exhausted = !pend_valid && (idx == count);

  assign issue = cmd.scan && !status.hit && (idx < count);
  assign room  = count < ipdt_pkg::CNT_W'(ipdt_pkg::CAPACITY);
  assign wr_en = cmd.resolve && !status.hit && room;

  ipdt_ram #(
    .WIDTH(ipdt_pkg::KEY_W),
    .DEPTH(ipdt_pkg::CAPACITY)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[ipdt_pkg::ADDR_W-1:0]),
    .wdata(key),
    .re   (issue),
    .raddr(idx[ipdt_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    count_next = count;
    pos        = '0;
    res_next   = res;
    if (cmd.resolve) begin
      priority if (status.hit) begin
        pos = pend_idx;
      end else if (room) begin
        pos        = count[ipdt_pkg::ADDR_W-1:0];
        count_next = count + 1'b1;
      end else begin
        pos = '0;
      end
      res_next.canonical_index = ipdt_pkg::IDX_OUT_W'(pos);
      res_next.was_added       = !status.hit && room;
      res_next.table_full      = !status.hit && !room;
      res_next.entry_count     = ipdt_pkg::CNT_OUT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx        <= '0;
        pend_valid <= 1'b0;
        if (pair.start_mesh) begin
          count <= '0;
        end
      end else begin
        count      <= count_next;
        pend_valid <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= {pair.vertex_index, pair.texcoord_index};
    end
    if (issue) begin
      pend_idx <= idx[ipdt_pkg::ADDR_W-1:0];
    end
    res <= res_next;
    if (cmd.publish) begin
      result <= res;
    end
  end

endmodule

@@ rtl/ipdt_ctrl.sv @@
// Controller: accept, scan, resolve and output beat sequencing.
`timescale 1ns / 1ps

module ipdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pair_valid,
  output logic              pair_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output ipdt_pkg::cmd_t    cmd,
  input  ipdt_pkg::status_t status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign pair_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pair_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit || status.exhausted) begin
          cmd.resolve = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/index_pair_dedup_table.sv @@
// Top level of the index pair dedup table.
`timescale 1ns / 1ps

// Takes one (vertex index, texcoord index) pair per input beat and returns one
// result beat: the table position of the first stored pair that matches, or of
// the pair just appended, with added/full flags and the entry count. A set
// start_mesh empties the table first. Pairs are handled one at a time; the
// table RAM is scanned from position 0, one entry a cycle through its single
// read port, until a match or the last stored entry. The input is taken again
// once the result sits in the output register, so a stalled result beat holds
// back at most one further pair.
// Once the table holds CAPACITY pairs, a miss is not stored and is reported
// with table_full and position 0. No clearing pass is needed after reset.

module index_pair_dedup_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              pair_valid,
  output logic              pair_stall,
  input  ipdt_pkg::pair_t   pair,
  output logic              result_valid,
  input  logic              result_stall,
  output ipdt_pkg::result_t result
);

  ipdt_pkg::cmd_t    cmd;
  ipdt_pkg::status_t status;

  ipdt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cmd         (cmd),
    .status      (status)
  );

  ipdt_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .status(status),
    .pair  (pair),
    .result(result)
  );

endmodule

@@ rtl/ipdt_checker.sv @@
// Port-level checks for the index pair dedup table, bound to the top level.
`timescale 1ns / 1ps

module ipdt_checker (
  input logic              clk,
  input logic              rst,
  input logic              pair_valid,
  input logic              pair_stall,
  input ipdt_pkg::pair_t   pair,
  input logic              result_valid,
  input logic              result_stall,
  input ipdt_pkg::result_t result
);

  // a held result beat keeps its contents
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // one pair at a time: the port closes right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    pair_valid && !pair_stall |=> pair_stall)
    else $error("second pair taken while one is in work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.was_added && result.table_full))
    else $error("was_added and table_full both set");

  // an appended pair lands at the last occupied position
  a_added_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.was_added |->
      result.canonical_index ==
        ipdt_pkg::IDX_OUT_W'(result.entry_count - 1'b1))
    else $error("appended position does not match entry count");

  a_full_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.table_full |-> result.canonical_index == '0)
    else $error("full table miss reports nonzero position");

endmodule

bind index_pair_dedup_table ipdt_checker u_ipdt_checker (.*);
